// ===== rtl/core/ubsr_pkg.sv =====
// Shared constants, handshake structs and state type for the swap-remove bag.
package ubsr_pkg;

	localparam int STORE_DEPTH  = 1024;
	localparam int MIN_CAPACITY = 10;
	localparam int NUM_CELLS    = 4;
	localparam int CELL_W       = $clog2(NUM_CELLS);
	localparam int BANK_DEPTH   = STORE_DEPTH / NUM_CELLS;
	localparam int ROW_W        = $clog2(BANK_DEPTH);
	localparam int SLOT_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W        = 11;
	localparam int VAL_W        = 64;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Search word handed from cell to cell, one bank row per word.
	typedef struct packed {
		logic              valid;
		logic [ROW_W-1:0]  row;
		logic              hit;
		logic [SLOT_W-1:0] hit_slot;
	} scan_tok_t;

	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] row;
		logic [VAL_W-1:0] data;
	} wr_req_t;

	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] row;
	} rd_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ_LAST,
		ST_MOVE,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/core/ubsr_cell.sv =====
// One search cell: a bank of the entry store plus a two-stage compare stage.
module ubsr_cell import ubsr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CELL_W-1:0] cell_idx,
	input  logic              flush,
	input  logic [VAL_W-1:0]  key,
	input  logic [CNT_W-1:0]  count,
	input  scan_tok_t         tok_in,
	output scan_tok_t         tok_out,
	input  rd_req_t           rd_req,
	input  wr_req_t           wr_req,
	output logic [VAL_W-1:0]  rd_data
);

	logic [VAL_W-1:0]  bank_mem [BANK_DEPTH];
	logic [VAL_W-1:0]  rdata_s1;
	scan_tok_t         tok_s1;
	scan_tok_t         tok_s2;
	scan_tok_t         tok_next;
	logic [ROW_W-1:0]  rd_row;
	logic [SLOT_W-1:0] slot;
	logic              in_range;
	logic              match;

	assign rd_row = rd_req.en ? rd_req.row : tok_in.row;

	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			bank_mem[wr_req.row] <= wr_req.data;
		end
		rdata_s1 <= bank_mem[rd_row];
	end

	// Slots interleave across the cells: slot = row * NUM_CELLS + cell index.
	assign slot     = {tok_s1.row, cell_idx};
	assign in_range = {1'b0, slot} < count;
	assign match    = tok_s1.valid && !tok_s1.hit && in_range && (rdata_s1 == key);

	always_comb begin
		tok_next = tok_s1;
		if (match) begin
			tok_next.hit      = 1'b1;
			tok_next.hit_slot = slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else if (flush) begin
			tok_s1.valid <= 1'b0;
			tok_s2.valid <= 1'b0;
		end else begin
			tok_s1 <= tok_in;
			tok_s2 <= tok_next;
		end
	end

	assign tok_out = tok_s2;
	assign rd_data = rdata_s1;

endmodule

// ===== rtl/core/unordered_bag_swap_remove_core.sv =====
// An add goes from IDLE straight to FINISH; a remove from a non-empty bag scans the rows
// through the 4-cell chain and, on a hit, passes READ_LAST and MOVE before FINISH.
// One item is in work at a time; the next is accepted once its result is registered.
// Reset clears the fill count and sets capacity to 1024; the store itself is not
// cleared, since only slots below the fill count are ever matched or moved.
module unordered_bag_swap_remove_core import ubsr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    operation,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    success,
	output logic [CNT_W-1:0]        fill_count,
	output logic                    is_empty,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CNT_W-1:0]        capacity
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  eff_cap;
	logic [VAL_W-1:0]  key_q;
	logic [ROW_W-1:0]  issue_row_q;
	logic [ROW_W-1:0]  last_row_q;
	logic              issuing_q;
	logic [SLOT_W-1:0] hit_slot_q;
	logic              ok_q;
	logic              out_valid_q;
	logic              success_q;
	logic [CNT_W-1:0]  fill_q;
	logic              empty_q;

	logic              accept;
	logic              out_free;
	logic              flush;
	logic [SLOT_W-1:0] last_slot;
	logic [CNT_W-1:0]  count_m1;

	logic              wr_en;
	logic [SLOT_W-1:0] wr_slot;
	logic [VAL_W-1:0]  wr_data;
	logic              rd_en;

	scan_tok_t         tok_head;
	scan_tok_t         tok_chain [NUM_CELLS+1];
	logic [VAL_W-1:0]  cell_rd_data [NUM_CELLS];
	scan_tok_t         tok_end;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign count_m1  = count_q - 1'b1;
	assign last_slot = count_m1[SLOT_W-1:0];
	assign tok_end   = tok_chain[NUM_CELLS];

	always_comb begin
		if (cap_q < CNT_W'(MIN_CAPACITY)) begin
			eff_cap = CNT_W'(MIN_CAPACITY);
		end else if (cap_q > CNT_W'(STORE_DEPTH)) begin
			eff_cap = CNT_W'(STORE_DEPTH);
		end else begin
			eff_cap = cap_q;
		end
	end

	// A word leaving the chain with a hit ends the scan; later rows are dropped.
	assign flush = (state_q == ST_SCAN) && tok_end.valid && tok_end.hit;

	always_comb begin
		tok_head          = '0;
		tok_head.valid    = (state_q == ST_SCAN) && issuing_q && !flush;
		tok_head.row      = issue_row_q;
	end

	assign tok_chain[0] = tok_head;

	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_slot = count_q[SLOT_W-1:0];
		wr_data = value;
		rd_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_ADD) begin
						wr_en   = (count_q < eff_cap);
						state_d = ST_FINISH;
					end else if (count_q == '0) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (tok_end.valid) begin
					if (tok_end.hit) begin
						state_d = ST_READ_LAST;
					end else if (tok_end.row == last_row_q) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_READ_LAST: begin
				rd_en   = 1'b1;
				state_d = ST_MOVE;
			end
			ST_MOVE: begin
				wr_en   = 1'b1;
				wr_slot = hit_slot_q;
				wr_data = cell_rd_data[last_slot[CELL_W-1:0]];
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CNT_W'(STORE_DEPTH);
			issuing_q   <= 1'b0;
			issue_row_q <= '0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= capacity;
			end
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ok_q        <= (operation == OP_ADD) && (count_q < eff_cap);
						issue_row_q <= '0;
						issuing_q   <= (operation == OP_REMOVE) && (count_q != '0);
						if ((operation == OP_ADD) && (count_q < eff_cap)) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (flush) begin
						issuing_q <= 1'b0;
					end else if (issuing_q) begin
						if (issue_row_q == last_row_q) begin
							issuing_q <= 1'b0;
						end else begin
							issue_row_q <= issue_row_q + 1'b1;
						end
					end
				end
				ST_MOVE: begin
					count_q <= count_m1;
					ok_q    <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q      <= value;
			last_row_q <= count_m1[SLOT_W-1:CELL_W];
		end
		if (flush) begin
			hit_slot_q <= tok_end.hit_slot;
		end
		if ((state_q == ST_FINISH) && out_free) begin
			success_q <= ok_q;
			fill_q    <= count_q;
			empty_q   <= (count_q == '0);
		end
	end

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		wr_req_t wr_req;
		rd_req_t rd_req;

		assign wr_req.en   = wr_en && (wr_slot[CELL_W-1:0] == CELL_W'(k));
		assign wr_req.row  = wr_slot[SLOT_W-1:CELL_W];
		assign wr_req.data = wr_data;
		assign rd_req.en   = rd_en && (last_slot[CELL_W-1:0] == CELL_W'(k));
		assign rd_req.row  = last_slot[SLOT_W-1:CELL_W];

		ubsr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (CELL_W'(k)),
			.flush    (flush),
			.key      (key_q),
			.count    (count_q),
			.tok_in   (tok_chain[k]),
			.tok_out  (tok_chain[k+1]),
			.rd_req   (rd_req),
			.wr_req   (wr_req),
			.rd_data  (cell_rd_data[k])
		);
	end

	assign out_valid  = out_valid_q;
	assign success    = success_q;
	assign fill_count = fill_q;
	assign is_empty   = empty_q;

endmodule

// ===== bench/tb_unordered_bag_swap_remove_core.sv =====
// Self-checking testbench for the swap-remove bag core: a directed table, then random phases.
module tb_unordered_bag_swap_remove_core import ubsr_pkg::*; ();

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_WORDS = 558;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic             success;
		logic [CNT_W-1:0] fill_count;
		logic             is_empty;
	} bag_result_t;

	typedef enum logic {ROW_WORD, ROW_CAPACITY} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		logic                    op;
		logic signed [VAL_W-1:0] val;
		bit                      typed;
		bag_result_t             res;
	} plan_row_t;

	logic                    clk;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    operation = OP_ADD;
	logic signed [VAL_W-1:0] value     = '0;
	logic                    out_stall = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic [CNT_W-1:0]        capacity  = '0;
	logic                    in_stall;
	logic                    out_valid;
	logic                    success;
	logic [CNT_W-1:0]        fill_count;
	logic                    is_empty;
	logic                    cfg_ready;

	// Predicted contents of the bag, its fill count and the capacity register.
	logic signed [VAL_W-1:0] bag_mem [STORE_DEPTH];
	int unsigned             bag_count    = 0;
	logic [CNT_W-1:0]        bag_capacity = 11'd1024;
	bag_result_t             expected_q [$];
	int                      errors = 0;
	int                      cycle_cnt = 0;
	bit                      quiet = 1'b0;

	unordered_bag_swap_remove_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.success    (success),
		.fill_count (fill_count),
		.is_empty   (is_empty),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.capacity   (capacity)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb_unordered_bag_swap_remove_core: FAIL");
		$finish;
	end

	function automatic bag_result_t bag_apply(input logic op, input logic signed [VAL_W-1:0] v);
		int unsigned limit;
		int unsigned slot;
		bag_result_t r;
		limit = {21'd0, bag_capacity};
		if (limit < MIN_CAPACITY) limit = MIN_CAPACITY;
		if (limit > STORE_DEPTH) limit = STORE_DEPTH;
		r.success = 1'b0;
		if (op == OP_ADD) begin
			if (bag_count < limit) begin
				bag_mem[bag_count] = v;
				bag_count++;
				r.success = 1'b1;
			end
		end else begin
			slot = 0;
			while (slot < bag_count && bag_mem[slot] !== v) slot++;
			// The last entry fills the hole left by the first match.
			if (slot < bag_count) begin
				bag_count--;
				bag_mem[slot] = bag_mem[bag_count];
				r.success = 1'b1;
			end
		end
		r.fill_count = bag_count[CNT_W-1:0];
		r.is_empty = (bag_count == 0);
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value(input logic op);
		int unsigned r;
		r = $urandom_range(0, 9);
		// Most removes search for a value the bag really holds.
		if (op == OP_REMOVE && bag_count != 0 && r < 6)
			return bag_mem[$urandom_range(0, bag_count - 1)];
		case (r)
			0, 1, 2: return $signed({32'd0, $urandom_range(0, 8)}) - 64'sd4;
			3: return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_word(input logic op, input logic signed [VAL_W-1:0] v, input bit typed,
			input bag_result_t typed_res);
		int gap;
		bag_result_t r;
		gap = quiet ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		value <= v;
		do @(posedge clk); while (in_stall);
		r = bag_apply(op, v);
		expected_q.push_back(typed ? typed_res : r);
	endtask

	// Drops valid and waits until no result is outstanding; with none it returns at once.
	task automatic wait_drained();
		if (expected_q.size() != 0) begin
			in_valid <= 1'b0;
			while (expected_q.size() != 0) @(posedge clk);
		end
	endtask

	task automatic set_capacity(input logic [CNT_W-1:0] cap);
		wait_drained();
		cfg_valid <= 1'b1;
		capacity <= cap;
		do @(posedge clk); while (!cfg_ready);
		bag_capacity = cap;
		cfg_valid <= 1'b0;
	endtask

	initial begin : result_checker
		int stall_cycles;
		bag_result_t want;
		@(posedge arst_n);
		forever begin
			stall_cycles = quiet ? 0 : $urandom_range(0, 12);
			if (stall_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (stall_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (expected_q.size() == 0) begin
				$display("%0t: result word with nothing expected: %s %0b %0d %0b",
					$time, "success, fill_count, is_empty", success, fill_count,
					is_empty);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (success !== want.success) begin
					$display("%0t: success expected %0b, got %0b", $time, want.success, success);
					errors++;
				end
				if (fill_count !== want.fill_count) begin
					$display("%0t: fill_count expected %0d, got %0d", $time, want.fill_count,
						fill_count);
					errors++;
				end
				if (is_empty !== want.is_empty) begin
					$display("%0t: is_empty expected %0b, got %0b", $time, want.is_empty, is_empty);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		plan_row_t plan [$];
		logic [CNT_W-1:0] cap;
		logic op;
		int random_words;
		int phase_len;
		int add_pct;
		plan = '{
			'{ROW_CAPACITY, OP_ADD,    64'sd0,   1'b0, '0},
			'{ROW_WORD,     OP_REMOVE, 64'sd0,   1'b1, '{1'b0, 11'd0,  1'b1}},
			'{ROW_WORD,     OP_ADD,    VAL_MIN,  1'b1, '{1'b1, 11'd1,  1'b0}},
			'{ROW_WORD,     OP_ADD,    VAL_MAX,  1'b1, '{1'b1, 11'd2,  1'b0}},
			'{ROW_WORD,     OP_ADD,    -64'sd1,  1'b1, '{1'b1, 11'd3,  1'b0}},
			'{ROW_WORD,     OP_ADD,    64'sd0,   1'b1, '{1'b1, 11'd4,  1'b0}},
			'{ROW_WORD,     OP_ADD,    VAL_MAX,  1'b1, '{1'b1, 11'd5,  1'b0}},
			'{ROW_WORD,     OP_ADD,    64'sd1,   1'b1, '{1'b1, 11'd6,  1'b0}},
			'{ROW_WORD,     OP_ADD,    64'sd2,   1'b1, '{1'b1, 11'd7,  1'b0}},
			'{ROW_WORD,     OP_ADD,    64'sd3,   1'b1, '{1'b1, 11'd8,  1'b0}},
			'{ROW_WORD,     OP_ADD,    64'sd4,   1'b1, '{1'b1, 11'd9,  1'b0}},
			'{ROW_WORD,     OP_ADD,    64'sd5,   1'b1, '{1'b1, 11'd10, 1'b0}},
			'{ROW_WORD,     OP_ADD,    64'sd6,   1'b1, '{1'b0, 11'd10, 1'b0}},
			'{ROW_WORD,     OP_REMOVE, VAL_MAX,  1'b1, '{1'b1, 11'd9,  1'b0}},
			'{ROW_WORD,     OP_REMOVE, 64'sd777, 1'b1, '{1'b0, 11'd9,  1'b0}},
			'{ROW_CAPACITY, OP_ADD,    64'sd5,   1'b0, '0},
			'{ROW_WORD,     OP_ADD,    64'sd7,   1'b0, '0},
			'{ROW_WORD,     OP_ADD,    64'sd8,   1'b0, '0},
			'{ROW_CAPACITY, OP_ADD,    64'sd2047, 1'b0, '0},
			'{ROW_WORD,     OP_ADD,    64'sd8,   1'b0, '0},
			'{ROW_CAPACITY, OP_ADD,    64'sd10,  1'b0, '0},
			'{ROW_WORD,     OP_ADD,    64'sd9,   1'b0, '0},
			'{ROW_WORD,     OP_REMOVE, VAL_MAX,  1'b0, '0},
			'{ROW_WORD,     OP_ADD,    64'sd9,   1'b0, '0},
			'{ROW_WORD,     OP_REMOVE, VAL_MIN,  1'b0, '0},
			'{ROW_WORD,     OP_REMOVE, VAL_MAX,  1'b0, '0}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CAPACITY)
				set_capacity(plan[i].val[CNT_W-1:0]);
			else
				send_word(plan[i].op, plan[i].val, plan[i].typed, plan[i].res);
		end
		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			case ($urandom_range(0, 7))
				0: cap = CNT_W'($urandom_range(0, MIN_CAPACITY - 1));
				1: cap = CNT_W'(MIN_CAPACITY);
				2, 3: cap = CNT_W'($urandom_range(MIN_CAPACITY + 1, 40));
				4: cap = CNT_W'(STORE_DEPTH);
				5: cap = CNT_W'($urandom_range(STORE_DEPTH + 1, 2047));
				// Capacity at the current fill count, which may sit below the minimum.
				6: cap = CNT_W'(bag_count);
				default: cap = CNT_W'($urandom_range(0, 2047));
			endcase
			set_capacity(cap);
			quiet = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 3))
				0: add_pct = 30;
				1: add_pct = 50;
				2: add_pct = 70;
				default: add_pct = 90;
			endcase
			phase_len = $urandom_range(30, 70);
			for (int k = 0; k < phase_len && random_words < RANDOM_WORDS; k++) begin
				if ($urandom_range(0, 39) == 0) wait_drained();
				op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_REMOVE;
				send_word(op, pick_value(op), 1'b0, '0);
				random_words++;
			end
		end
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("tb_unordered_bag_swap_remove_core: PASS");
		end else begin
			$display("tb_unordered_bag_swap_remove_core: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/ubsr_pkg.sv
rtl/core/ubsr_cell.sv
rtl/core/unordered_bag_swap_remove_core.sv
bench/tb_unordered_bag_swap_remove_core.sv
